// ===== rtl/fre_pkg.sv =====
// ----------------------------------------------------------------------------
// fre_pkg
// Shared types and constants of the four register instruction executor.
// ----------------------------------------------------------------------------
package fre_pkg;

  localparam int MEM_WORDS_DEF  = 1024;
  localparam int PROG_WORDS_DEF = 1024;
  localparam int PC_W           = 11;
  localparam int DATA_W         = 32;

  typedef enum logic [3:0] {
    OP_MOV_I  = 4'd0,
    OP_ADD_I  = 4'd1,
    OP_SUB_I  = 4'd2,
    OP_MUL_I  = 4'd3,
    OP_DIV_I  = 4'd4,
    OP_MOV_R  = 4'd5,
    OP_ADD_R  = 4'd6,
    OP_SUB_R  = 4'd7,
    OP_MUL_R  = 4'd8,
    OP_DIV_R  = 4'd9,
    OP_LOAD   = 4'd10,
    OP_STORE  = 4'd11,
    OP_JMP    = 4'd12,
    OP_JMPZ   = 4'd13
  } op_t;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_DIV0 = 2'd1;
  localparam logic [1:0] FAULT_ADDR = 2'd2;

  localparam logic [1:0] REG_PROG_LEN = 2'd0;

  typedef struct packed {
    logic [3:0]        func;
    logic [1:0]        reg_a;
    logic [1:0]        reg_b;
    logic [DATA_W-1:0] immediate;
  } instr_t;

  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic              finished;
    logic [DATA_W-1:0] r0_value;
    logic [DATA_W-1:0] written_value;
    logic [1:0]        fault;
  } result_t;

endpackage

// ===== rtl/fre_instr_if.sv =====
// ----------------------------------------------------------------------------
// fre_instr_if
// Valid/ready channel carrying one decoded instruction item.
// ----------------------------------------------------------------------------
interface fre_instr_if;
  import fre_pkg::*;
  logic              valid;
  logic              ready;
  logic [3:0]        func;
  logic [1:0]        reg_a;
  logic [1:0]        reg_b;
  logic [DATA_W-1:0] immediate;
  modport source (output valid, func, reg_a, reg_b, immediate, input ready);
  modport sink   (input valid, func, reg_a, reg_b, immediate, output ready);
endinterface

// ===== rtl/fre_result_if.sv =====
// ----------------------------------------------------------------------------
// fre_result_if
// Valid/ready channel carrying one execution result item.
// ----------------------------------------------------------------------------
interface fre_result_if;
  import fre_pkg::*;
  logic              valid;
  logic              ready;
  logic [PC_W-1:0]   next_pc;
  logic              finished;
  logic [DATA_W-1:0] r0_value;
  logic [DATA_W-1:0] written_value;
  logic [1:0]        fault;
  modport source (output valid, next_pc, finished, r0_value, written_value, fault,
                  input ready);
  modport sink   (input valid, next_pc, finished, r0_value, written_value, fault,
                  output ready);
endinterface

// ===== rtl/fre_ram.sv =====
// ----------------------------------------------------------------------------
// fre_ram
// Generic single port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module fre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one access per cycle, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/fre_divider.sv =====
// ----------------------------------------------------------------------------
// fre_divider
// Iterative signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module fre_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import fre_pkg::*;

  logic        busy;
  logic [5:0]  count;
  logic [31:0] q;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic        neg;
  logic [32:0] rem_shift;
  logic [32:0] diff;

  // restoring step
  assign rem_shift = {rem[31:0], q[31]};
  assign diff      = rem_shift - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'd0;
        q     <= dividend[31] ? 32'd0 - dividend : dividend;
        dvs   <= divisor[31] ? 32'd0 - divisor : divisor;
        neg   <= dividend[31] ^ divisor[31];
        rem   <= 33'd0;
      end else if (busy) begin
        if (diff[32]) begin
          rem <= rem_shift;
          q   <= {q[30:0], 1'b0};
        end else begin
          rem <= diff;
          q   <= {q[30:0], 1'b1};
        end
        count <= count + 6'd1;
        if (count == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? 32'd0 - q : q;
endmodule

// ===== rtl/four_register_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// four_register_instruction_executor
// Executes one decoded instruction per item on four registers, a word
// memory and a program counter.
//
//   channel  | dir | payload
//   instr    | in  | func, reg_a, reg_b, immediate
//   result   | out | next_pc, finished, r0_value, written_value, fault
//   apb      | in  | program_length at address 0
//
// One item at a time. Mov/add/sub, jumps, store, faults and unused codes go
// from the execute state straight to the output state; mul and load pass
// through S_MUL or S_MEM first, and division by a nonzero divisor waits in
// S_DIV for the one-bit-per-cycle divider to finish.
// rst is synchronous; registers and counter clear, memory is not cleared.
// A finished result waits in the output register; the next item is taken
// once that result is gone.
// ----------------------------------------------------------------------------
module four_register_instruction_executor #(
  parameter int MEM_WORDS  = fre_pkg::MEM_WORDS_DEF,
  parameter int PROG_WORDS = fre_pkg::PROG_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  fre_instr_if.sink   instr,
  fre_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fre_pkg::*;

  localparam int MA_W = $clog2(MEM_WORDS);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MUL, S_DIV, S_MEM, S_OUT
  } state_t;

  state_t            state;
  instr_t            ir;
  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   program_length;
  logic [31:0]       regs [4];
  logic [31:0]       cur, opnd, prod, res;
  logic [PC_W-1:0]   next_adv, jmp_tgt;
  logic              addr_ok;
  logic              mem_we;
  logic [31:0]       mem_rdata;
  logic              div_start, div_done;
  logic [31:0]       div_q;
  logic [31:0]       out_written;
  logic [1:0]        out_fault;
  logic [PC_W-1:0]   out_pc;
  logic              out_valid;
  logic [1:0]        dst;
  logic              wr_reg;
  logic [31:0]       wr_val;
  logic              take_jmp;
  logic [1:0]        exec_fault;
  logic [31:0]       exec_written;
  state_t            exec_state;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_PROG_LEN) ? {21'd0, program_length} : 32'd0;

  // operand selection
  assign cur  = regs[ir.reg_a];
  assign opnd = (ir.func >= OP_MOV_R) ? regs[ir.reg_b] : ir.immediate;
  assign addr_ok = (ir.immediate[31] == 1'b0) &&
                   ({1'b0, ir.immediate} < 33'(MEM_WORDS));

  // counter update
  assign next_adv = ({21'd0, pc} >= 32'(PROG_WORDS)) ? PC_W'(PROG_WORDS) : pc + 1'b1;
  assign jmp_tgt  = (ir.immediate > 32'(PROG_WORDS)) ? PC_W'(PROG_WORDS)
                                                     : ir.immediate[PC_W-1:0];

  assign mem_we    = (state == S_EXEC) && (ir.func == OP_STORE) && addr_ok;
  assign div_start = (state == S_EXEC) && (opnd != 32'd0) &&
                     ((ir.func == OP_DIV_I) || (ir.func == OP_DIV_R));

  fre_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (ir.immediate[MA_W-1:0]),
    .wdata (cur),
    .rdata (mem_rdata)
  );

  fre_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cur),
    .divisor  (opnd),
    .done     (div_done),
    .quotient (div_q)
  );

  // simple alu result
  always_comb begin
    case (ir.func)
      OP_MOV_I, OP_MOV_R: res = opnd;
      OP_ADD_I, OP_ADD_R: res = cur + opnd;
      OP_SUB_I, OP_SUB_R: res = cur - opnd;
      default:            res = 32'd0;
    endcase
  end

  // decode of the execute step: fault, written value, jump and next state
  always_comb begin
    take_jmp     = 1'b0;
    exec_fault   = FAULT_NONE;
    exec_written = 32'd0;
    exec_state   = S_OUT;
    case (ir.func) inside
      [OP_MOV_I:OP_SUB_I], [OP_MOV_R:OP_SUB_R]: exec_written = res;
      OP_MUL_I, OP_MUL_R: exec_state = S_MUL;
      OP_DIV_I, OP_DIV_R: begin
        if (opnd == 32'd0) exec_fault = FAULT_DIV0;
        else exec_state = S_DIV;
      end
      OP_LOAD, OP_STORE: begin
        if (!addr_ok) exec_fault = FAULT_ADDR;
        else if (ir.func == OP_STORE) exec_written = cur;
        else exec_state = S_MEM;
      end
      OP_JMP:  take_jmp = 1'b1;
      OP_JMPZ: take_jmp = (regs[0] == 32'd0);
      default: ;
    endcase
  end

  // register file write selection
  always_comb begin
    wr_reg = 1'b0;
    wr_val = res;
    dst    = ir.reg_a;
    case (state)
      S_EXEC:  wr_reg = (ir.func inside {OP_MOV_I, OP_ADD_I, OP_SUB_I,
                                        OP_MOV_R, OP_ADD_R, OP_SUB_R});
      S_MUL: begin
        wr_reg = 1'b1;
        wr_val = prod;
      end
      S_DIV: begin
        wr_reg = div_done;
        wr_val = div_q;
      end
      S_MEM: begin
        wr_reg = (ir.func == OP_LOAD);
        wr_val = mem_rdata;
      end
      default: wr_reg = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_reg) begin
      regs[dst] <= wr_val;
    end
    if (rst) begin
      for (int i = 0; i < 4; i++) regs[i] <= 32'd0;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pc             <= '0;
      program_length <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == REG_PROG_LEN) begin
        program_length <= pwdata[PC_W-1:0];
      end
      case (state)
        S_IDLE: begin
          if (instr.valid) begin
            ir    <= '{instr.func, instr.reg_a, instr.reg_b, instr.immediate};
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_pc      <= take_jmp ? jmp_tgt : next_adv;
          out_fault   <= exec_fault;
          out_written <= exec_written;
          prod        <= cur * opnd;
          state       <= exec_state;
        end
        S_MUL: begin
          out_written <= prod;
          state       <= S_OUT;
        end
        S_DIV: begin
          if (div_done) begin
            out_written <= div_q;
            state       <= S_OUT;
          end
        end
        S_MEM: begin
          out_written <= mem_rdata;
          state       <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            pc        <= out_pc;
          end else if (result.ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign instr.ready          = (state == S_IDLE);
  assign result.valid         = out_valid;
  assign result.next_pc       = out_pc;
  assign result.finished      = (out_pc >= program_length);
  assign result.r0_value      = regs[0];
  assign result.written_value = out_written;
  assign result.fault         = out_fault;
endmodule

// ===== tb/fre_result_checker.sv =====
// ----------------------------------------------------------------------------
// fre_result_checker
// Watches the instruction, result and register channels of the executor,
// keeps its own copy of the machine state and checks every result in order.
// ----------------------------------------------------------------------------
module fre_result_checker (
  input  logic         clk,
  input  logic         rst,
  fre_instr_if         instr,
  fre_result_if        result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           fail_count,
  output int           pending
);
  import fre_pkg::*;

  localparam int MEM_WORDS  = MEM_WORDS_DEF;
  localparam int PROG_WORDS = PROG_WORDS_DEF;

  // shadow machine state
  logic [DATA_W-1:0] regs [4];
  logic [DATA_W-1:0] mem [MEM_WORDS];
  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   prog_len;
  result_t           expected_results[$];

  // signed divide truncating toward zero, min / -1 wraps
  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ua, ub, q;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    q  = ua / ub;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // execute one instruction on the shadow state
  function automatic result_t exec_instr(instr_t it);
    result_t     r;
    logic [31:0] opnd, cur, res, wr;
    logic [31:0] nxt;
    logic [1:0]  flt;
    logic        do_wr;
    wr    = '0;
    flt   = FAULT_NONE;
    nxt   = (pc >= PROG_WORDS) ? PROG_WORDS : pc + 1;
    opnd  = (it.func >= OP_MOV_R) ? regs[it.reg_b] : it.immediate;
    cur   = regs[it.reg_a];
    res   = '0;
    do_wr = 1'b0;
    case (it.func)
      OP_MOV_I, OP_MOV_R: begin
        res = opnd; do_wr = 1'b1;
      end
      OP_ADD_I, OP_ADD_R: begin
        res = cur + opnd; do_wr = 1'b1;
      end
      OP_SUB_I, OP_SUB_R: begin
        res = cur - opnd; do_wr = 1'b1;
      end
      OP_MUL_I, OP_MUL_R: begin
        res = cur * opnd; do_wr = 1'b1;
      end
      OP_DIV_I, OP_DIV_R: begin
        if (opnd == 0) flt = FAULT_DIV0;
        else begin
          res = div_trunc(cur, opnd); do_wr = 1'b1;
        end
      end
      OP_LOAD, OP_STORE: begin
        if (it.immediate >= MEM_WORDS) flt = FAULT_ADDR;
        else if (it.func == OP_LOAD) begin
          res = mem[it.immediate[9:0]]; do_wr = 1'b1;
        end else begin
          mem[it.immediate[9:0]] = cur;
          wr = cur;
        end
      end
      OP_JMP: nxt = (it.immediate > PROG_WORDS) ? PROG_WORDS : it.immediate;
      OP_JMPZ: begin
        if (regs[0] == 0)
          nxt = (it.immediate > PROG_WORDS) ? PROG_WORDS : it.immediate;
      end
      default: ;
    endcase
    if (do_wr) begin
      regs[it.reg_a] = res;
      wr = res;
    end
    pc              = nxt[PC_W-1:0];
    r.next_pc       = pc;
    r.finished      = (pc >= prog_len);
    r.r0_value      = regs[0];
    r.written_value = wr;
    r.fault         = flt;
    return r;
  endfunction

  // observe channels, predict and compare
  always @(posedge clk) begin
    instr_t  it;
    result_t exp_r, act;
    if (rst) begin
      for (int i = 0; i < 4; i++) regs[i] = '0;
      pc = '0;
      prog_len = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_PROG_LEN)
        prog_len = pwdata[PC_W-1:0];
      if (result.valid && result.ready) begin
        act.next_pc       = result.next_pc;
        act.finished      = result.finished;
        act.r0_value      = result.r0_value;
        act.written_value = result.written_value;
        act.fault         = result.fault;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result item: pc=%0d r0=%h wr=%h fault=%0d",
                     act.next_pc, act.r0_value, act.written_value, act.fault);
        end else begin
          exp_r = expected_results.pop_front();
          if (act.next_pc !== exp_r.next_pc || act.finished !== exp_r.finished ||
              act.r0_value !== exp_r.r0_value ||
              act.written_value !== exp_r.written_value ||
              act.fault !== exp_r.fault) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp pc=%0d fin=%0d r0=%h wr=%h fault=%0d / act pc=%0d fin=%0d r0=%h wr=%h fault=%0d",
                       exp_r.next_pc, exp_r.finished, exp_r.r0_value,
                       exp_r.written_value, exp_r.fault, act.next_pc, act.finished,
                       act.r0_value, act.written_value, act.fault);
          end
        end
      end
      if (instr.valid && instr.ready) begin
        it.func      = instr.func;
        it.reg_a     = instr.reg_a;
        it.reg_b     = instr.reg_b;
        it.immediate = instr.immediate;
        expected_results = {expected_results, exec_instr(it)};
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/four_register_instruction_executor_tb.sv =====
// ----------------------------------------------------------------------------
// four_register_instruction_executor_tb
// Drives directed and random instruction items through the executor under
// several program lengths, with bursty input and stalling output; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module four_register_instruction_executor_tb;
  import fre_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          burst_left;
  logic        stored [MEM_WORDS_DEF];
  int          stored_addrs[$];

  fre_instr_if  instr_ch ();
  fre_result_if result_ch ();

  four_register_instruction_executor u_top (
    .clk     (clk),
    .rst     (rst),
    .instr   (instr_ch.sink),
    .result  (result_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fre_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .instr      (instr_ch),
    .result     (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

  // receiver: changing stall pattern plus one long hold-off
  initial begin
    int cyc;
    int hold;
    int mode;
    cyc = 0;
    hold = 0;
    mode = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 600 == 0) mode = $urandom_range(0, 3);
      if (cyc == 5000) hold = 400;
      if (hold > 0) begin
        hold--;
        result_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= ($urandom_range(0, 1) == 1);
          2: result_ch.ready <= ($urandom_range(0, 3) != 0);
          default: result_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  task automatic write_prog_len(input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_PROG_LEN;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait for the block to drain before touching its register
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // offer one item, hold until taken, then maybe open a gap
  task automatic send_instr(input logic [3:0] f, input logic [1:0] ra,
                            input logic [1:0] rb, input logic [31:0] imm);
    if (f == OP_STORE && imm < MEM_WORDS_DEF && !stored[imm[9:0]]) begin
      stored[imm[9:0]] = 1'b1;
      stored_addrs = {stored_addrs, int'(imm)};
    end
    instr_ch.valid     <= 1'b1;
    instr_ch.func      <= f;
    instr_ch.reg_a     <= ra;
    instr_ch.reg_b     <= rb;
    instr_ch.immediate <= imm;
    do @(posedge clk); while (!instr_ch.ready);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 3) != 0) begin
        instr_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
    end
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 8);
      4: return -$urandom_range(1, 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_addr(input logic for_load);
    case ($urandom_range(0, 5))
      0: return -$urandom_range(1, 100);
      1: return $urandom_range(MEM_WORDS_DEF, MEM_WORDS_DEF + 50);
      2: return for_load ? (32'h8000_0000 | $urandom) : $urandom;
      default: begin
        if (for_load)
          return (stored_addrs.size() > 0) ?
                 stored_addrs[$urandom_range(0, stored_addrs.size() - 1)] : 32'hffff_ffff;
        return $urandom_range(0, MEM_WORDS_DEF - 1);
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_target();
    case ($urandom_range(0, 4))
      0: return PROG_WORDS_DEF;
      1: return $urandom_range(PROG_WORDS_DEF + 1, 5000);
      2: return $urandom;
      default: return $urandom_range(0, PROG_WORDS_DEF - 1);
    endcase
  endfunction

  task automatic send_random();
    logic [3:0]  f;
    logic [31:0] imm;
    f = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) f = OP_MOV_I;
    case (f)
      OP_LOAD:          imm = rand_addr(1'b1);
      OP_STORE:         imm = rand_addr(1'b0);
      OP_JMP, OP_JMPZ:  imm = rand_target();
      default:          imm = rand_value();
    endcase
    // keep R0 at zero now and then so conditional jumps get taken
    if (f == OP_MOV_I && $urandom_range(0, 2) == 0) send_instr(f, 2'd0, 2'd0, 32'd0);
    else send_instr(f, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), imm);
  endtask

  // stimulus and verdict
  initial begin
    logic [31:0] lens [6];
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    instr_ch.valid     <= 1'b0;
    instr_ch.func      <= '0;
    instr_ch.reg_a     <= '0;
    instr_ch.reg_b     <= '0;
    instr_ch.immediate <= '0;
    burst_left = 0;
    for (int i = 0; i < MEM_WORDS_DEF; i++) stored[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every operation, faults and jump saturation
    write_prog_len(32'd20);
    send_instr(OP_MOV_I,  2'd0, 2'd0, 32'h8000_0000);
    send_instr(OP_MOV_I,  2'd1, 2'd0, 32'h7fff_ffff);
    send_instr(OP_ADD_I,  2'd1, 2'd0, 32'd1);
    send_instr(OP_SUB_I,  2'd1, 2'd0, 32'd1);
    send_instr(OP_MUL_I,  2'd1, 2'd0, 32'hffff_ffff);
    send_instr(OP_DIV_I,  2'd1, 2'd0, 32'd0);
    send_instr(OP_DIV_I,  2'd0, 2'd0, 32'hffff_ffff);
    send_instr(OP_MOV_I,  2'd2, 2'd0, 32'hffff_ffff);
    send_instr(OP_MOV_R,  2'd3, 2'd0, 32'd0);
    send_instr(OP_DIV_R,  2'd3, 2'd2, 32'd0);
    send_instr(OP_ADD_R,  2'd3, 2'd1, 32'd0);
    send_instr(OP_SUB_R,  2'd3, 2'd2, 32'd0);
    send_instr(OP_MUL_R,  2'd3, 2'd3, 32'd0);
    send_instr(OP_DIV_I,  2'd1, 2'd0, 32'hffff_fff9);
    send_instr(OP_STORE,  2'd1, 2'd0, 32'd1023);
    send_instr(OP_STORE,  2'd3, 2'd0, 32'd0);
    send_instr(OP_LOAD,   2'd2, 2'd0, 32'd1023);
    send_instr(OP_LOAD,   2'd2, 2'd0, 32'd1024);
    send_instr(OP_STORE,  2'd2, 2'd0, 32'hffff_ffff);
    send_instr(OP_JMP,    2'd0, 2'd0, 32'd5);
    send_instr(OP_JMP,    2'd0, 2'd0, 32'hffff_ffff);
    send_instr(OP_MOV_I,  2'd0, 2'd0, 32'd0);
    send_instr(OP_DIV_R,  2'd1, 2'd0, 32'd0);
    send_instr(OP_JMPZ,   2'd0, 2'd0, 32'd2000);
    send_instr(OP_MOV_I,  2'd0, 2'd0, 32'd7);
    send_instr(OP_JMPZ,   2'd0, 2'd0, 32'd3);
    send_instr(4'd14,     2'd1, 2'd2, 32'h5555_aaaa);
    send_instr(4'd15,     2'd3, 2'd3, 32'haaaa_5555);

    // random phases under several program lengths, block drained between
    lens[0] = 32'd0;
    lens[1] = 32'd1024;
    lens[2] = 32'd1;
    lens[3] = $urandom_range(2, 1023);
    lens[4] = 32'd17;
    lens[5] = 32'd1024;
    for (int p = 0; p < 6; p++) begin
      instr_ch.valid <= 1'b0;
      drain();
      write_prog_len(lens[p]);
      repeat (85) send_random();
    end
    instr_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
